[src/rfp_pkg.sv]
// Package for the rangefinder frame parser.
// Constants, codes, state type and window types; no dependencies.
`default_nettype none
package rfp_pkg;

    localparam int LONG_FRAME_BYTES  = 13;
    localparam int SHORT_FRAME_BYTES = 9;
    localparam int MAX_DECISIONS     = 5;
    localparam int FILL_W            = $clog2(LONG_FRAME_BYTES + 1);
    localparam int IDX_W             = $clog2(LONG_FRAME_BYTES);
    localparam int RANGE_W           = 18;
    localparam int BCD_W             = 15;
    localparam int CNT_W             = $clog2(MAX_DECISIONS + 1);
    localparam int ADDR_W            = 3;
    localparam int DATA_W            = 32;

    localparam logic [7:0] SYNC_A    = 8'hAA;
    localparam logic [7:0] SYNC_E    = 8'hEE;
    localparam logic [7:0] CMD_LONG  = 8'h04;
    localparam logic [7:0] CMD_ECHO  = 8'h01;

    localparam logic [RANGE_W-1:0] MIN_RANGE_RESET = RANGE_W'(50);
    localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = RANGE_W'(50000);

    // register select, taken from paddr[2]
    localparam logic REG_MIN_RANGE = 1'b0;
    localparam logic REG_MAX_RANGE = 1'b1;

    localparam logic [1:0] STAT_IN_RANGE  = 2'd0;
    localparam logic [1:0] STAT_OUT_RANGE = 2'd1;
    localparam logic [1:0] STAT_ECHO      = 2'd2;
    localparam logic [1:0] STAT_INVALID   = 2'd3;

    localparam logic [1:0] FMT_SHORT = 2'd0;
    localparam logic [1:0] FMT_LONG  = 2'd1;
    localparam logic [1:0] FMT_EE    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_EVAL,
        ST_SCALE,
        ST_RANGE,
        ST_DROP,
        ST_SCAN
    } state_t;

    typedef logic [LONG_FRAME_BYTES-1:0][7:0] window_t;

    typedef struct packed {
        logic       append;
        logic       shift;
        logic [7:0] data;
    } window_ctl_t;

endpackage
`default_nettype wire

[src/rfp_if.sv]
// Channel interfaces for the rangefinder frame parser: input byte and result beat.
// Depends on rfp_pkg.
`default_nettype none
interface rfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfp_result_if;
    import rfp_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [1:0]         frame_format;
    logic [RANGE_W-1:0] distance_mm;
    logic               last;

    modport source (output valid, output status, output frame_format,
                    output distance_mm, output last, input ready);
    modport sink   (input valid, input status, input frame_format,
                    input distance_mm, input last, output ready);
endinterface
`default_nettype wire

[src/rfp_window.sv]
// Byte window of the frame parser: append, shift by one, fill count, indexed read.
// Depends on rfp_pkg.
`default_nettype none
module rfp_window (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire rfp_pkg::window_ctl_t      ctl,
    input  wire logic [rfp_pkg::IDX_W-1:0] rd_idx,
    output logic [7:0]                     rd_data,
    output rfp_pkg::window_t               bytes,
    output logic [rfp_pkg::FILL_W-1:0]     fill
);
    import rfp_pkg::*;

    window_t           bytes_reg;
    logic [FILL_W-1:0] fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (ctl.append)
        begin
            if (fill_reg >= FILL_W'(LONG_FRAME_BYTES))
                fill_reg <= FILL_W'(1);
            else
                fill_reg <= fill_reg + FILL_W'(1);
        end
        else if (ctl.shift && fill_reg != '0)
        begin
            fill_reg <= fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.append)
        begin
            if (fill_reg >= FILL_W'(LONG_FRAME_BYTES))
                bytes_reg[0] <= ctl.data;
            else
                bytes_reg[fill_reg[IDX_W-1:0]] <= ctl.data;
        end
        else if (ctl.shift)
        begin
            for (int i = 0; i < LONG_FRAME_BYTES - 1; i++)
                bytes_reg[i] <= bytes_reg[i+1];
        end
    end

    assign rd_data = bytes_reg[rd_idx];
    assign bytes   = bytes_reg;
    assign fill    = fill_reg;

endmodule
`default_nettype wire

[src/rangefinder_frame_parser.sv]
// Rangefinder frame parser top level. Depends on rfp_pkg, rfp_if, rfp_window.
// A byte that causes no decision passes only through idle and check; each decision adds
// a checksum adder walk of one byte per cycle, then decode, scale, range compare, and
// a window shift of one byte per cycle for the consumed and skipped bytes.
// One byte is in work at a time; up to five results per byte leave through an output register.
// Reset clears the window fill, the sequencer and the output, and loads the range limits.
`default_nettype none
module rangefinder_frame_parser (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [rfp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rfp_pkg::DATA_W-1:0] pwdata,
    output logic [rfp_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    rfp_byte_if.sink                       byte_in,
    rfp_result_if.source                   result_out
);
    import rfp_pkg::*;

    logic [RANGE_W-1:0] min_range_reg;
    logic [RANGE_W-1:0] max_range_reg;

    state_t state_reg, state_next;

    window_ctl_t       win_ctl;
    logic [IDX_W-1:0]  rd_idx;
    logic [7:0]        rd_data;
    window_t           w;
    logic [FILL_W-1:0] fill;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [7:0]         acc_reg, acc_next;
    logic               sum9_ok_reg, sum9_ok_next;
    logic               sum13_ok_reg, sum13_ok_next;
    logic               meas_reg, meas_next;
    logic               scale_reg, scale_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [FILL_W-1:0]  drop_reg, drop_next;
    logic [1:0]         pend_status_reg, pend_status_next;
    logic [1:0]         pend_fmt_reg, pend_fmt_next;
    logic [RANGE_W-1:0] pend_dist_reg, pend_dist_next;
    logic               pend_valid_reg, pend_valid_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg, out_fmt_reg;
    logic [RANGE_W-1:0] out_dist_reg;
    logic               out_last_reg;

    logic               accept, in_sync, is_ee, long_try, follows, slot_free, out_load;
    logic               sum_done;
    logic [7:0]         sum_val;
    logic [1:0]         ev_status, ev_fmt;
    logic               ev_meas, ev_scale;
    logic [7:0]         ev_hi, ev_lo;
    logic [FILL_W-1:0]  ev_used;

    rfp_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (win_ctl),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .bytes   (w),
        .fill    (fill)
    );

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_RANGE) ? DATA_W'(max_range_reg)
                                                : DATA_W'(min_range_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg <= MIN_RANGE_RESET;
            max_range_reg <= MAX_RANGE_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_MIN_RANGE)
                min_range_reg <= pwdata[RANGE_W-1:0];
            else
                max_range_reg <= pwdata[RANGE_W-1:0];
        end
    end

    // shared decode terms
    assign accept    = byte_in.valid && byte_in.ready;
    assign in_sync   = (byte_in.rx_byte == SYNC_A) || (byte_in.rx_byte == SYNC_E);
    assign is_ee     = (w[0] == SYNC_E);
    assign long_try  = !is_ee && (w[4] == 8'h00) && (w[5] == CMD_LONG);
    assign follows   = (count_reg < CNT_W'(MAX_DECISIONS))
                       && (fill >= FILL_W'(SHORT_FRAME_BYTES))
                       && !(long_try && (fill < FILL_W'(LONG_FRAME_BYTES)));
    assign slot_free = !out_valid_reg || result_out.ready;
    assign out_load  = (state_reg == ST_CHECK) && pend_valid_reg && slot_free;
    assign sum_val   = acc_reg + rd_data;
    assign sum_done  = (idx_reg == IDX_W'(SHORT_FRAME_BYTES - 2) && !long_try)
                       || (idx_reg == IDX_W'(LONG_FRAME_BYTES - 2));
    assign rd_idx    = idx_reg;

    // frame decision from the window and checksum flags
    always_comb
    begin
        ev_status = STAT_INVALID;
        ev_fmt    = FMT_SHORT;
        ev_meas   = 1'b0;
        ev_scale  = 1'b0;
        ev_hi     = w[5];
        ev_lo     = w[6];
        ev_used   = FILL_W'(1);
        if (is_ee)
        begin
            ev_fmt = FMT_EE;
            if (sum9_ok_reg)
            begin
                ev_meas  = 1'b1;
                ev_scale = 1'b1;
                ev_used  = FILL_W'(SHORT_FRAME_BYTES);
            end
        end
        else if (long_try && sum13_ok_reg)
        begin
            ev_fmt  = FMT_LONG;
            ev_meas = 1'b1;
            ev_hi   = w[8];
            ev_lo   = w[9];
            ev_used = FILL_W'(LONG_FRAME_BYTES);
        end
        else if (w[4] == 8'h00 && w[5] == CMD_ECHO)
        begin
            ev_status = STAT_ECHO;
            ev_used   = FILL_W'(SHORT_FRAME_BYTES);
        end
        else if (sum9_ok_reg && w[4] == 8'h00 && w[5] != 8'h00)
        begin
            ev_meas = 1'b1;
            ev_used = FILL_W'(SHORT_FRAME_BYTES);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !(fill == '0 && !in_sync))
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!pend_valid_reg || slot_free)
                    state_next = follows ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                if (sum_done)
                    state_next = ST_EVAL;
            end
            ST_EVAL:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_RANGE;
            ST_RANGE: state_next = ST_DROP;
            ST_DROP:
            begin
                if (drop_reg == '0 || fill == '0)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (fill == '0 || w[0] == SYNC_A || w[0] == SYNC_E)
                    state_next = ST_CHECK;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and window control
    always_comb
    begin
        win_ctl          = '0;
        win_ctl.data     = byte_in.rx_byte;
        count_next       = count_reg;
        idx_next         = idx_reg;
        acc_next         = acc_reg;
        sum9_ok_next     = sum9_ok_reg;
        sum13_ok_next    = sum13_ok_reg;
        meas_next        = meas_reg;
        scale_next       = scale_reg;
        bcd_next         = bcd_reg;
        drop_next        = drop_reg;
        pend_status_next = pend_status_reg;
        pend_fmt_next    = pend_fmt_reg;
        pend_dist_next   = pend_dist_reg;
        pend_valid_next  = pend_valid_reg;
        out_valid_next   = result_out.ready ? 1'b0 : out_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !(fill == '0 && !in_sync))
                begin
                    win_ctl.append = 1'b1;
                    count_next     = '0;
                end
            end
            ST_CHECK:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                end
                idx_next = IDX_W'(1);
                acc_next = '0;
            end
            ST_SUM:
            begin
                acc_next = sum_val;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(SHORT_FRAME_BYTES - 2))
                    sum9_ok_next = (sum_val == w[SHORT_FRAME_BYTES-1]);
                if (idx_reg == IDX_W'(LONG_FRAME_BYTES - 2))
                    sum13_ok_next = (sum_val == w[LONG_FRAME_BYTES-1]);
            end
            ST_EVAL:
            begin
                count_next       = count_reg + CNT_W'(1);
                meas_next        = ev_meas;
                scale_next       = ev_scale;
                drop_next        = ev_used;
                pend_status_next = ev_status;
                pend_fmt_next    = ev_fmt;
                bcd_next         = BCD_W'(ev_hi[7:4]) * BCD_W'(1000)
                                 + BCD_W'(ev_hi[3:0]) * BCD_W'(100)
                                 + BCD_W'(ev_lo[7:4]) * BCD_W'(10)
                                 + BCD_W'(ev_lo[3:0]);
            end
            ST_SCALE:
            begin
                if (!meas_reg)
                    pend_dist_next = '0;
                else if (scale_reg)
                    pend_dist_next = {bcd_reg, 3'b000} + RANGE_W'({bcd_reg, 1'b0});
                else
                    pend_dist_next = RANGE_W'(bcd_reg);
            end
            ST_RANGE:
            begin
                if (meas_reg)
                    pend_status_next = (pend_dist_reg >= min_range_reg
                                        && pend_dist_reg <= max_range_reg)
                                       ? STAT_IN_RANGE : STAT_OUT_RANGE;
                pend_valid_next = 1'b1;
            end
            ST_DROP:
            begin
                if (drop_reg != '0 && fill != '0)
                begin
                    win_ctl.shift = 1'b1;
                    drop_next     = drop_reg - FILL_W'(1);
                end
            end
            ST_SCAN:
            begin
                if (fill != '0 && w[0] != SYNC_A && w[0] != SYNC_E)
                    win_ctl.shift = 1'b1;
            end
            default:
            begin
                win_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        acc_reg         <= acc_next;
        sum9_ok_reg     <= sum9_ok_next;
        sum13_ok_reg    <= sum13_ok_next;
        meas_reg        <= meas_next;
        scale_reg       <= scale_next;
        bcd_reg         <= bcd_next;
        drop_reg        <= drop_next;
        pend_status_reg <= pend_status_next;
        pend_fmt_reg    <= pend_fmt_next;
        pend_dist_reg   <= pend_dist_next;
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_fmt_reg    <= pend_fmt_reg;
            out_dist_reg   <= pend_dist_reg;
            out_last_reg   <= !follows;
        end
    end

    assign byte_in.ready           = (state_reg == ST_IDLE);
    assign result_out.valid        = out_valid_reg;
    assign result_out.status       = out_status_reg;
    assign result_out.frame_format = out_fmt_reg;
    assign result_out.distance_mm  = out_dist_reg;
    assign result_out.last         = out_last_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= FILL_W'(LONG_FRAME_BYTES))
        else $error("window fill above window depth");

    a_decision_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DECISIONS))
        else $error("more decisions than allowed for one beat");

    a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        byte_in.ready |-> !pend_valid_reg)
        else $error("input taken with a result still pending");

    a_sum_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (fill >= FILL_W'(SHORT_FRAME_BYTES)))
        else $error("checksum walk on a short window");

    a_load_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> result_out.valid)
        else $error("result load lost");

endmodule
`default_nettype wire

[dv/rangefinder_frame_parser_test.sv]
// Self-checking bench for rangefinder_frame_parser: a directed byte script, then random
// frame traffic under several idle/stall patterns and range-limit settings.
// Depends on rfp_pkg, rfp_if and the parser RTL.
module rangefinder_frame_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfp_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_BYTES    = 80;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         fmt;
        logic [RANGE_W-1:0] distance;
        logic               last;
    } range_result_t;

    typedef struct packed {
        logic [7:0]         rx;
        logic               typed;
        logic [1:0]         status;
        logic [1:0]         fmt;
        logic [RANGE_W-1:0] distance;
    } script_row_t;

    localparam int SCRIPT_LEN = 42;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{8'h00, 1'b0, '0, '0, '0},
        // 0xAA window fails, rescan lands on an 0xEE frame with all nibbles at 15
        '{8'hAA, 1'b0, '0, '0, '0},
        '{8'hEE, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'hFF, 1'b0, '0, '0, '0},
        '{8'hFF, 1'b0, '0, '0, '0},
        '{8'h00, 1'b1, STAT_INVALID, FMT_SHORT, '0},
        '{8'hFE, 1'b1, STAT_OUT_RANGE, FMT_EE, 18'd166650},
        // long frame, parser must hold at 9 bytes; distance at the lower limit
        '{8'hAA, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h04, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h50, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h54, 1'b1, STAT_IN_RANGE, FMT_LONG, 18'd50},
        // command echo
        '{8'hAA, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h01, 1'b0, '0, '0, '0},
        '{8'h37, 1'b0, '0, '0, '0},
        '{8'hC8, 1'b0, '0, '0, '0},
        '{8'h5A, 1'b1, STAT_ECHO, FMT_SHORT, '0},
        // short frame
        '{8'hAA, 1'b0, '0, '0, '0},
        '{8'h11, 1'b0, '0, '0, '0},
        '{8'h22, 1'b0, '0, '0, '0},
        '{8'h33, 1'b0, '0, '0, '0},
        '{8'h00, 1'b0, '0, '0, '0},
        '{8'h12, 1'b0, '0, '0, '0},
        '{8'h34, 1'b0, '0, '0, '0},
        '{8'h45, 1'b0, '0, '0, '0},
        '{8'hF1, 1'b1, STAT_IN_RANGE, FMT_SHORT, 18'd1234}
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rfp_byte_if   byte_ch ();
    rfp_result_if result_ch ();

    rangefinder_frame_parser uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .byte_in    (byte_ch),
        .result_out (result_ch)
    );

    // parser image
    logic [7:0]         win [LONG_FRAME_BYTES];
    int                 win_fill;
    logic [RANGE_W-1:0] lim_min;
    logic [RANGE_W-1:0] lim_max;

    range_result_t readings_due [$];
    logic [7:0]    burst [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_armed    = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bit is_sync(logic [7:0] b);
        return b == SYNC_A || b == SYNC_E;
    endfunction

    function automatic bit frame_sum_ok(int n);
        logic [7:0] s = 8'h00;
        for (int i = 1; i + 1 < n; i++)
            s += win[i];
        return s == win[n-1];
    endfunction

    function automatic logic [RANGE_W-1:0] bcd_distance(logic [7:0] hi, logic [7:0] lo);
        return RANGE_W'(32'(hi[7:4]) * 1000 + 32'(hi[3:0]) * 100 +
                        32'(lo[7:4]) * 10 + 32'(lo[3:0]));
    endfunction

    function automatic void drop_window(int n);
        int k = 0;
        if (n >= win_fill)
        begin
            win_fill = 0;
            return;
        end
        for (int i = 0; i < win_fill - n; i++)
            win[i] = win[i+n];
        win_fill -= n;
        while (k < win_fill && !is_sync(win[k]))
            k++;
        for (int i = 0; i < win_fill - k; i++)
            win[i] = win[i+k];
        win_fill -= k;
    endfunction

    // returns bytes consumed, 0 while the window needs more bytes
    function automatic int judge_frame(output range_result_t r);
        bit meas = 1'b0;
        int used = 1;
        r = '0;
        if (win_fill < SHORT_FRAME_BYTES)
            return 0;
        if (win[0] == SYNC_E)
        begin
            r.fmt = FMT_EE;
            if (frame_sum_ok(SHORT_FRAME_BYTES))
            begin
                r.distance = RANGE_W'(bcd_distance(win[5], win[6]) * 10);
                meas = 1'b1;
                used = SHORT_FRAME_BYTES;
            end
        end
        else
        begin
            r.fmt = FMT_SHORT;
            if (win[4] == 8'h00 && win[5] == CMD_LONG)
            begin
                if (win_fill < LONG_FRAME_BYTES)
                    return 0;
                if (frame_sum_ok(LONG_FRAME_BYTES))
                begin
                    r.fmt = FMT_LONG;
                    r.distance = bcd_distance(win[8], win[9]);
                    meas = 1'b1;
                    used = LONG_FRAME_BYTES;
                end
            end
            if (!meas)
            begin
                if (win[4] == 8'h00 && win[5] == CMD_ECHO)
                begin
                    r.status = STAT_ECHO;
                    return SHORT_FRAME_BYTES;
                end
                if (frame_sum_ok(SHORT_FRAME_BYTES) && win[4] == 8'h00 && win[5] != 8'h00)
                begin
                    r.distance = bcd_distance(win[5], win[6]);
                    meas = 1'b1;
                    used = SHORT_FRAME_BYTES;
                end
            end
        end
        if (!meas)
        begin
            r.status = STAT_INVALID;
            r.distance = '0;
            return 1;
        end
        r.status = (r.distance >= lim_min && r.distance <= lim_max) ? STAT_IN_RANGE
                                                                    : STAT_OUT_RANGE;
        return used;
    endfunction

    task automatic parse_byte(input logic [7:0] b, output int n_new);
        range_result_t r;
        int used;
        n_new = 0;
        if (win_fill == 0 && !is_sync(b))
            return;
        if (win_fill >= LONG_FRAME_BYTES)
            win_fill = 0;
        win[win_fill] = b;
        win_fill++;
        while (n_new < MAX_DECISIONS)
        begin
            used = judge_frame(r);
            if (used == 0)
                break;
            readings_due.push_back(r);
            n_new++;
            drop_window(used);
        end
        if (n_new > 0)
            readings_due[readings_due.size()-1].last = 1'b1;
    endtask

    function automatic logic [7:0] digit_pair();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom);
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0: return SYNC_A;
            1: return SYNC_E;
            2: return 8'h00;
            3: return CMD_ECHO;
            4: return CMD_LONG;
            default: return 8'($urandom);
        endcase
    endfunction

    // one random frame, mostly well formed, sometimes corrupted, cut short or plain noise
    task automatic make_burst();
        logic [7:0] f [LONG_FRAME_BYTES];
        logic [7:0] s;
        int kind;
        int len;
        int flaw;
        int pos;
        burst.delete();
        kind = $urandom_range(0, 9);
        len = SHORT_FRAME_BYTES;
        for (int i = 0; i < LONG_FRAME_BYTES; i++)
            f[i] = 8'($urandom);
        if (kind >= 8)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                burst.push_back(noise_byte());
            return;
        end
        case (kind)
            0, 1, 2:
            begin
                f[0] = SYNC_A;
                f[4] = 8'h00;
                do
                    f[5] = digit_pair();
                while (f[5] == 8'h00 || f[5] == CMD_ECHO || f[5] == CMD_LONG);
                f[6] = digit_pair();
            end
            3, 4:
            begin
                f[0] = SYNC_A;
                f[4] = 8'h00;
                f[5] = CMD_LONG;
                f[8] = digit_pair();
                f[9] = digit_pair();
                len = LONG_FRAME_BYTES;
            end
            5, 6:
            begin
                f[0] = SYNC_E;
                f[5] = digit_pair();
                f[6] = digit_pair();
            end
            default:
            begin
                f[0] = SYNC_A;
                f[4] = 8'h00;
                f[5] = CMD_ECHO;
            end
        endcase
        s = 8'h00;
        for (int i = 1; i < len - 1; i++)
            s += f[i];
        f[len-1] = s;
        flaw = $urandom_range(0, 9);
        if (flaw == 0)
        begin
            pos = $urandom_range(1, len - 1);
            f[pos][$urandom_range(0, 7)] ^= 1'b1;
        end
        else if (flaw == 1)
            len = $urandom_range(1, len - 1);
        for (int i = 0; i < len; i++)
            burst.push_back(f[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, output int n_new);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        parse_byte(b, n_new);
    endtask

    task automatic write_limit(input logic reg_sel, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_sel == REG_MIN_RANGE)
            lim_min = value[RANGE_W-1:0];
        else
            lim_max = value[RANGE_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic finish_phase();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n_bytes);
        int sent = 0;
        int n_new;
        while (sent < n_bytes)
        begin
            make_burst();
            foreach (burst[i])
                send_byte(burst[i], n_new);
            sent += burst.size();
        end
        finish_phase();
    endtask

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_armed && !hold_taken)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
            result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        range_result_t got;
        range_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = {result_ch.status, result_ch.frame_format, result_ch.distance_mm,
                   result_ch.last};
            if (readings_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected beat: status %0d format %0d distance %0d last %0d",
                             got.status, got.fmt, got.distance, got.last);
            end
            else
            begin
                want = readings_due.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"beat mismatch (exp/got): status %0d/%0d format %0d/%0d ",
                                  "distance %0d/%0d last %0d/%0d"},
                                 want.status, got.status, want.fmt, got.fmt,
                                 want.distance, got.distance, want.last, got.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int n_new;
        range_result_t fixed;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = 8'h00;
        result_ch.ready = 1'b0;
        win_fill        = 0;
        lim_min         = MIN_RANGE_RESET;
        lim_max         = MAX_RANGE_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            send_byte(SCRIPT[i].rx, n_new);
            if (SCRIPT[i].typed)
            begin
                repeat (n_new) void'(readings_due.pop_back());
                fixed.status   = SCRIPT[i].status;
                fixed.fmt      = SCRIPT[i].fmt;
                fixed.distance = SCRIPT[i].distance;
                fixed.last     = 1'b1;
                readings_due.push_back(fixed);
            end
        end
        finish_phase();

        // widest limits, no idling, long receiver hold-off
        write_limit(REG_MIN_RANGE, 32'd0);
        write_limit(REG_MAX_RANGE, 32'hFFFF_FFFF);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_armed    = 1'b1;
        run_random(PHASE_BYTES);

        write_limit(REG_MIN_RANGE, 32'd2000);
        write_limit(REG_MAX_RANGE, 32'd6000);
        send_idle_pct = 81;
        stall_pct     = 0;
        run_random(PHASE_BYTES);

        // min above max: every measurement out of range
        write_limit(REG_MIN_RANGE, 32'd166650);
        write_limit(REG_MAX_RANGE, 32'd0);
        send_idle_pct = 0;
        stall_pct     = 81;
        run_random(PHASE_BYTES);

        write_limit(REG_MIN_RANGE, 32'd1000);
        write_limit(REG_MAX_RANGE, 32'd99990);
        send_idle_pct = 25;
        stall_pct     = 25;
        run_random(PHASE_BYTES);

        if (mismatch_count == 0 && readings_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[rangefinder_frame_parser.f]
src/rfp_pkg.sv
src/rfp_if.sv
src/rfp_window.sv
src/rangefinder_frame_parser.sv
dv/rangefinder_frame_parser_test.sv
